@@ rtl/core/clp_pkg.sv @@
// Shared constants and types for the polygon clipper core.
package clp_pkg;

    // Width of the clipping square side register
    localparam int SIZE_WIDTH = 23;
    // Side length after reset (256.0 with 8 fraction bits)
    localparam logic [SIZE_WIDTH-1:0] CLIP_SIZE_RESET = SIZE_WIDTH'(65536);
    // Default coordinate width
    localparam int COORD_WIDTH_DEF = 24;
    // Number of half-plane cells in the chain
    localparam int NUM_CELLS = 4;

    // Half-plane cell sequencer states
    typedef enum logic [2:0] {
        CS_IDLE,
        CS_EMIT_A,
        CS_MUL,
        CS_DIV,
        CS_EMIT_X,
        CS_CLOSE,
        CS_EMIT_END
    } t_cell_state;

endpackage

@@ rtl/core/clp_div.sv @@
// Restoring divider, one quotient bit per cycle.
module clp_div #(
    parameter int DW = 25
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [2*DW-1:0]   i_num,
    input  logic [DW-1:0]     i_den,
    output logic              o_done,
    output logic [DW-1:0]     o_q
);
    localparam int PW = 2 * DW;
    localparam int CW = $clog2(DW + 1);

    logic [PW-1:0] r_rem;
    logic [PW-1:0] r_dsh;
    logic [DW-1:0] r_q;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;
    logic          w_ge;

    assign w_ge   = (r_rem >= r_dsh);
    assign o_done = r_done;
    assign o_q    = r_q;

    // Control: count quotient steps
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(DW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: trial subtract and shift in one quotient bit
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_num;
            r_dsh <= {{DW{1'b0}}, i_den} << (DW - 1);
            r_q   <= '0;
        end else if (r_busy) begin
            if (w_ge) begin
                r_rem <= r_rem - r_dsh;
            end
            r_q   <= {r_q[DW-2:0], w_ge};
            r_dsh <= r_dsh >> 1;
        end
    end

endmodule

@@ rtl/core/clp_cell.sv @@
// One half-plane clipping cell of the chain.
module clp_cell #(
    parameter int W     = clp_pkg::COORD_WIDTH_DEF,
    parameter int STAGE = 0
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [clp_pkg::SIZE_WIDTH-1:0] i_size,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [W-1:0]           i_x,
    input  logic signed [W-1:0]           i_y,
    input  logic                          i_vtx,
    input  logic                          i_end,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic signed [W-1:0]           o_x,
    output logic signed [W-1:0]           o_y,
    output logic                          o_vtx,
    output logic                          o_end
);
    localparam int  SW     = clp_pkg::SIZE_WIDTH;
    localparam int  EW     = (W > SW + 1) ? W : SW + 1;
    localparam int  DW     = EW + 1;
    localparam bit  AXIS_Y = (STAGE >= 2);
    localparam bit  HIGH   = ((STAGE % 2) == 1);

    clp_pkg::t_cell_state r_state, n_state, w_after;

    logic                r_started;
    logic signed [W-1:0] r_fx, r_fy, r_px, r_py;
    logic signed [W-1:0] r_ax, r_ay, r_bx, r_by;
    logic signed [W-1:0] r_rx, r_ry;
    logic                r_close, r_fin, r_neg;

    logic signed [EW:0]  w_ua, w_ub, w_va, w_vb, w_c, w_lim;
    logic signed [EW:0]  w_dnum, w_part, w_whole;
    logic [DW-1:0]       w_mn, w_mp, w_mw;
    logic [2*DW-1:0]     w_prod;
    logic                w_ia, w_ib;
    logic                w_div_start, w_div_done;
    logic [DW-1:0]       w_q;
    logic signed [EW+1:0] w_v;

    // Pick coordinates along and across the clipping axis
    always_comb begin
        if (AXIS_Y) begin
            w_ua = {{(EW+1-W){r_ay[W-1]}}, r_ay};
            w_ub = {{(EW+1-W){r_by[W-1]}}, r_by};
            w_va = {{(EW+1-W){r_ax[W-1]}}, r_ax};
            w_vb = {{(EW+1-W){r_bx[W-1]}}, r_bx};
        end else begin
            w_ua = {{(EW+1-W){r_ax[W-1]}}, r_ax};
            w_ub = {{(EW+1-W){r_bx[W-1]}}, r_bx};
            w_va = {{(EW+1-W){r_ay[W-1]}}, r_ay};
            w_vb = {{(EW+1-W){r_by[W-1]}}, r_by};
        end
    end

    assign w_lim = {{(EW+1-SW){1'b0}}, i_size};
    assign w_c   = HIGH ? w_lim : '0;
    assign w_ia  = HIGH ? (w_ua <= w_lim) : (w_ua >= 0);
    assign w_ib  = HIGH ? (w_ub <= w_lim) : (w_ub >= 0);

    // Crossing terms: dnum * part / whole
    assign w_dnum  = w_vb - w_va;
    assign w_part  = w_c - w_ua;
    assign w_whole = w_ub - w_ua;
    assign w_mn    = w_dnum[EW]  ? DW'(-w_dnum)  : DW'(w_dnum);
    assign w_mp    = w_part[EW]  ? DW'(-w_part)  : DW'(w_part);
    assign w_mw    = w_whole[EW] ? DW'(-w_whole) : DW'(w_whole);
    assign w_prod  = {{DW{1'b0}}, w_mn} * {{DW{1'b0}}, w_mp};

    clp_div #(.DW(DW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_prod),
        .i_den   (w_mw),
        .o_done  (w_div_done),
        .o_q     (w_q)
    );

    // Apply the signed quotient to the cross coordinate
    always_comb begin
        if (w_mw == '0) begin
            w_v = {w_va[EW], w_va};
        end else if (r_neg) begin
            w_v = {w_va[EW], w_va} - $signed({1'b0, w_q});
        end else begin
            w_v = {w_va[EW], w_va} + $signed({1'b0, w_q});
        end
    end

    // Where to go once an edge is done
    always_comb begin
        if (r_close) begin
            w_after = clp_pkg::CS_CLOSE;
        end else if (r_fin) begin
            w_after = clp_pkg::CS_EMIT_END;
        end else begin
            w_after = clp_pkg::CS_IDLE;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            clp_pkg::CS_IDLE: begin
                if (i_valid) begin
                    if (i_vtx) begin
                        if (r_started) begin
                            n_state = clp_pkg::CS_EMIT_A;
                        end else if (i_end) begin
                            n_state = clp_pkg::CS_CLOSE;
                        end
                    end else begin
                        n_state = clp_pkg::CS_CLOSE;
                    end
                end
            end
            clp_pkg::CS_EMIT_A: begin
                if (!w_ia || !i_stall) begin
                    n_state = (w_ia != w_ib) ? clp_pkg::CS_MUL : w_after;
                end
            end
            clp_pkg::CS_MUL: n_state = clp_pkg::CS_DIV;
            clp_pkg::CS_DIV: begin
                if (w_div_done) begin
                    n_state = clp_pkg::CS_EMIT_X;
                end
            end
            clp_pkg::CS_EMIT_X: begin
                if (!i_stall) begin
                    n_state = w_after;
                end
            end
            clp_pkg::CS_CLOSE: begin
                n_state = r_started ? clp_pkg::CS_EMIT_A : clp_pkg::CS_EMIT_END;
            end
            clp_pkg::CS_EMIT_END: begin
                if (!i_stall) begin
                    n_state = clp_pkg::CS_IDLE;
                end
            end
            default: n_state = clp_pkg::CS_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_stall     = (r_state != clp_pkg::CS_IDLE);
        w_div_start = (r_state == clp_pkg::CS_MUL);
        o_valid     = 1'b0;
        o_x         = r_ax;
        o_y         = r_ay;
        o_vtx       = 1'b1;
        o_end       = 1'b0;
        case (r_state)
            clp_pkg::CS_EMIT_A: o_valid = w_ia;
            clp_pkg::CS_EMIT_X: begin
                o_valid = 1'b1;
                o_x     = r_rx;
                o_y     = r_ry;
            end
            clp_pkg::CS_EMIT_END: begin
                o_valid = 1'b1;
                o_vtx   = 1'b0;
                o_end   = 1'b1;
            end
            default: o_valid = 1'b0;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= clp_pkg::CS_IDLE;
            r_started <= 1'b0;
            r_close   <= 1'b0;
            r_fin     <= 1'b0;
        end else begin
            r_state <= n_state;
            case (r_state)
                clp_pkg::CS_IDLE: begin
                    if (i_valid) begin
                        r_close <= i_end;
                        if (i_vtx && !r_started) begin
                            r_started <= 1'b1;
                        end
                    end
                end
                clp_pkg::CS_CLOSE: begin
                    r_close   <= 1'b0;
                    r_fin     <= 1'b1;
                    r_started <= 1'b0;
                end
                clp_pkg::CS_EMIT_END: begin
                    if (!i_stall) begin
                        r_fin <= 1'b0;
                    end
                end
                default: r_fin <= r_fin;
            endcase
        end
    end

    // Vertex and crossing registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            clp_pkg::CS_IDLE: begin
                if (i_valid && i_vtx) begin
                    r_px <= i_x;
                    r_py <= i_y;
                    if (r_started) begin
                        r_ax <= r_px;
                        r_ay <= r_py;
                        r_bx <= i_x;
                        r_by <= i_y;
                    end else begin
                        r_fx <= i_x;
                        r_fy <= i_y;
                    end
                end
            end
            clp_pkg::CS_CLOSE: begin
                r_ax <= r_px;
                r_ay <= r_py;
                r_bx <= r_fx;
                r_by <= r_fy;
            end
            clp_pkg::CS_MUL: begin
                r_neg <= w_dnum[EW] ^ w_part[EW] ^ w_whole[EW];
            end
            clp_pkg::CS_DIV: begin
                if (w_div_done) begin
                    if (AXIS_Y) begin
                        r_rx <= w_v[W-1:0];
                        r_ry <= w_c[W-1:0];
                    end else begin
                        r_rx <= w_c[W-1:0];
                        r_ry <= w_v[W-1:0];
                    end
                end
            end
            default: r_neg <= r_neg;
        endcase
    end

endmodule

@@ rtl/core/clp_sink.sv @@
// Output hold stage: delays each vertex by one to tag the ring end.
module clp_sink #(
    parameter int W = clp_pkg::COORD_WIDTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic signed [W-1:0] i_x,
    input  logic signed [W-1:0] i_y,
    input  logic                i_vtx,
    input  logic                i_end,
    output logic                o_valid,
    input  logic                i_stall,
    output logic signed [W-1:0] o_x,
    output logic signed [W-1:0] o_y,
    output logic                o_vld,
    output logic                o_last
);
    logic                r_hv;
    logic signed [W-1:0] r_hx, r_hy;
    logic                r_ov;
    logic signed [W-1:0] r_ox, r_oy;
    logic                r_ovld, r_olast;
    logic                w_take;
    logic                w_emit;

    assign o_stall = r_ov && i_stall;
    assign w_take  = i_valid && !o_stall;
    assign w_emit  = w_take && (i_end || r_hv);

    assign o_valid = r_ov;
    assign o_x     = r_ox;
    assign o_y     = r_oy;
    assign o_vld   = r_ovld;
    assign o_last  = r_olast;

    // Track the hold and output register occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hv <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (w_emit) begin
                r_ov <= 1'b1;
            end else if (!i_stall) begin
                r_ov <= 1'b0;
            end
            if (w_take) begin
                r_hv <= i_vtx && !i_end;
            end
        end
    end

    // Load held vertex and the outgoing transaction
    always_ff @(posedge i_clk) begin
        if (w_take && i_vtx) begin
            r_hx <= i_x;
            r_hy <= i_y;
        end
        if (w_emit) begin
            r_ox    <= r_hv ? r_hx : '0;
            r_oy    <= r_hv ? r_hy : '0;
            r_ovld  <= r_hv;
            r_olast <= i_end;
        end
    end

endmodule

@@ rtl/core/polygon_clip_to_square.sv @@
// Top level of the polygon clipper: config register, cell chain and output stage.
// Clips a stream of closed polygon rings against the square [0, clip_size] on both
// axes. Vertices enter one per transaction, ring_last on the final one; results leave
// one vertex behind, the ring's final result flagged by out_last, and an empty ring
// yields one result with out_valid low. Four cells (x >= 0, x <= size, y >= 0,
// y <= size) run as a chain, each busy with one vertex at a time, so throughput is
// set by the busiest cell. A ring's last vertex adds the closing edge and the end
// marker, and each edge crossing in a cell waits for that cell's one-bit-per-cycle
// divider.
// Write clip_size only while idle.
module polygon_clip_to_square_core #(
    parameter int COORD_WIDTH = clp_pkg::COORD_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [clp_pkg::SIZE_WIDTH-1:0] i_cfg_wdata,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [COORD_WIDTH-1:0] i_vertex_x,
    input  logic signed [COORD_WIDTH-1:0] i_vertex_y,
    input  logic                          i_ring_last,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic signed [COORD_WIDTH-1:0] o_out_x,
    output logic signed [COORD_WIDTH-1:0] o_out_y,
    output logic                          o_out_valid,
    output logic                          o_out_last
);
    localparam int N = clp_pkg::NUM_CELLS;

    logic [clp_pkg::SIZE_WIDTH-1:0] r_clip_size;

    logic                          w_valid [N+1];
    logic                          w_stall [N+1];
    logic signed [COORD_WIDTH-1:0] w_x     [N+1];
    logic signed [COORD_WIDTH-1:0] w_y     [N+1];
    logic                          w_vtx   [N+1];
    logic                          w_end   [N+1];

    // Hold the square side length
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clip_size <= clp_pkg::CLIP_SIZE_RESET;
        end else if (i_cfg_we) begin
            r_clip_size <= i_cfg_wdata;
        end
    end

    assign w_valid[0] = i_valid;
    assign o_stall    = w_stall[0];
    assign w_x[0]     = i_vertex_x;
    assign w_y[0]     = i_vertex_y;
    assign w_vtx[0]   = 1'b1;
    assign w_end[0]   = i_ring_last;

    // Chain of half-plane cells
    for (genvar g = 0; g < N; g++) begin : g_cell
        clp_cell #(.W(COORD_WIDTH), .STAGE(g)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_size  (r_clip_size),
            .i_valid (w_valid[g]),
            .o_stall (w_stall[g]),
            .i_x     (w_x[g]),
            .i_y     (w_y[g]),
            .i_vtx   (w_vtx[g]),
            .i_end   (w_end[g]),
            .o_valid (w_valid[g+1]),
            .i_stall (w_stall[g+1]),
            .o_x     (w_x[g+1]),
            .o_y     (w_y[g+1]),
            .o_vtx   (w_vtx[g+1]),
            .o_end   (w_end[g+1])
        );
    end

    clp_sink #(.W(COORD_WIDTH)) u_sink (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_valid[N]),
        .o_stall (w_stall[N]),
        .i_x     (w_x[N]),
        .i_y     (w_y[N]),
        .i_vtx   (w_vtx[N]),
        .i_end   (w_end[N]),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_x     (o_out_x),
        .o_y     (o_out_y),
        .o_vld   (o_out_valid),
        .o_last  (o_out_last)
    );

endmodule

@@ tb/tb_polygon_clip_to_square_core.sv @@
// Testbench for the polygon clipper core: directed and random rings checked against a predictor.
`timescale 1ns / 100ps

module tb_polygon_clip_to_square_core;

    localparam int CW = clp_pkg::COORD_WIDTH_DEF;
    localparam int SW = clp_pkg::SIZE_WIDTH;
    localparam int NCELL = clp_pkg::NUM_CELLS;
    localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};
    localparam logic [SW-1:0] SMAX = '1;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic                 vld;
        logic                 last;
    } clip_out_t;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [SW-1:0]        i_cfg_wdata = '0;
    logic                 i_valid = 1'b0;
    logic                 o_stall;
    logic signed [CW-1:0] i_vertex_x = '0;
    logic signed [CW-1:0] i_vertex_y = '0;
    logic                 i_ring_last = 1'b0;
    logic                 o_valid;
    logic                 i_stall = 1'b0;
    logic signed [CW-1:0] o_out_x;
    logic signed [CW-1:0] o_out_y;
    logic                 o_out_valid;
    logic                 o_out_last;

    polygon_clip_to_square_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_valid(i_valid), .o_stall(o_stall), .i_vertex_x(i_vertex_x),
        .i_vertex_y(i_vertex_y), .i_ring_last(i_ring_last), .o_valid(o_valid),
        .i_stall(i_stall), .o_out_x(o_out_x), .o_out_y(o_out_y),
        .o_out_valid(o_out_valid), .o_out_last(o_out_last)
    );

    always #1 i_clk = ~i_clk;

    // Predictor state: clip size, per-cell first/prev vertex, output hold register
    logic [SW-1:0]        pr_size;
    logic signed [CW-1:0] pr_fx [NCELL];
    logic signed [CW-1:0] pr_fy [NCELL];
    logic signed [CW-1:0] pr_px [NCELL];
    logic signed [CW-1:0] pr_py [NCELL];
    logic                 pr_started [NCELL];
    logic                 pr_hold;
    logic signed [CW-1:0] pr_hx, pr_hy;

    clip_out_t clipped_q[$];
    int        n_err = 0;
    int        n_vtx = 0;
    int        n_res = 0;
    int        n_rings = 0;
    int        n_empty = 0;
    bit        rx_free = 1'b0;   // drop receiver idling
    bit        rx_block = 1'b0;  // long receiver hold-off

    // Report one mismatch and count it
    task automatic report_mismatch(input string what, input longint got, input longint want);
        n_err++;
        $display("ERROR %0t: %s got %0d expected %0d", $time, what, got, want);
    endtask

    function automatic bit in_plane(int c, logic signed [CW-1:0] x, logic signed [CW-1:0] y);
        longint lim;
        lim = longint'(pr_size);
        case (c)
            0: return x >= 0;
            1: return longint'(x) <= lim;
            2: return y >= 0;
            default: return longint'(y) <= lim;
        endcase
    endfunction

    // Offset base by trunc(dn * part / whole) with truncation toward zero
    function automatic longint interp(longint base, longint dn, longint part, longint whole);
        longint q;
        if (whole == 0) return base;
        q = (dn * part) / whole;
        return base + q;
    endfunction

    // Queue one expected result transaction
    task automatic expect_result(logic signed [CW-1:0] x, logic signed [CW-1:0] y,
                                 logic vld, logic lst);
        clip_out_t e;
        e.x = x;
        e.y = y;
        e.vld = vld;
        e.last = lst;
        clipped_q.insert(clipped_q.size(), e);
    endtask

    task automatic hold_push(logic signed [CW-1:0] x, logic signed [CW-1:0] y);
        if (pr_hold) expect_result(pr_hx, pr_hy, 1'b1, 1'b0);
        pr_hx = x;
        pr_hy = y;
        pr_hold = 1'b1;
    endtask

    task automatic cell_edge(int c, logic signed [CW-1:0] ax, logic signed [CW-1:0] ay,
                             logic signed [CW-1:0] bx, logic signed [CW-1:0] by);
        bit ia, ib;
        longint lc, rx, ry;
        ia = in_plane(c, ax, ay);
        ib = in_plane(c, bx, by);
        if (ia) pass_on(c + 1, ax, ay);
        if (ia != ib) begin
            lc = (c == 0 || c == 2) ? 0 : longint'(pr_size);
            if (c < 2) begin
                rx = lc;
                ry = interp(ay, longint'(by) - ay, lc - ax, longint'(bx) - ax);
            end else begin
                ry = lc;
                rx = interp(ax, longint'(bx) - ax, lc - ay, longint'(by) - ay);
            end
            pass_on(c + 1, CW'(rx), CW'(ry));
        end
    endtask

    task automatic pass_on(int c, logic signed [CW-1:0] x, logic signed [CW-1:0] y);
        logic signed [CW-1:0] ax, ay;
        if (c >= NCELL) begin
            hold_push(x, y);
        end else if (!pr_started[c]) begin
            pr_fx[c] = x; pr_fy[c] = y; pr_px[c] = x; pr_py[c] = y;
            pr_started[c] = 1'b1;
        end else begin
            ax = pr_px[c]; ay = pr_py[c];
            pr_px[c] = x; pr_py[c] = y;
            cell_edge(c, ax, ay, x, y);
        end
    endtask

    // Work out the clipped results caused by one vertex
    task automatic predict_clip(logic signed [CW-1:0] x, logic signed [CW-1:0] y, logic lst);
        pass_on(0, x, y);
        if (lst) begin
            for (int c = 0; c < NCELL; c++) begin
                if (pr_started[c]) begin
                    pr_started[c] = 1'b0;
                    cell_edge(c, pr_px[c], pr_py[c], pr_fx[c], pr_fy[c]);
                end
            end
            if (pr_hold) expect_result(pr_hx, pr_hy, 1'b1, 1'b1);
            else begin
                expect_result('0, '0, 1'b0, 1'b1);
                n_empty++;
            end
            pr_hold = 1'b0;
            n_rings++;
        end
    endtask

    // Send one vertex transaction, with random idle before it when gaps is set
    task automatic send_vertex(logic signed [CW-1:0] x, logic signed [CW-1:0] y, logic lst,
                               bit gaps = 1'b1);
        while (gaps && $urandom_range(99) < 16) @(negedge i_clk);
        i_valid = 1'b1;
        i_vertex_x <= x;
        i_vertex_y <= y;
        i_ring_last <= lst;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predict_clip(x, y, lst);
        n_vtx++;
        @(negedge i_clk);
        i_valid = 1'b0;
    endtask

    task automatic wait_drained();
        while (clipped_q.size() != 0) @(negedge i_clk);
        repeat (200) @(negedge i_clk);
    endtask

    task automatic write_size(logic [SW-1:0] v);
        wait_drained();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        pr_size = v;
    endtask

    function automatic logic signed [CW-1:0] rand_coord(logic [SW-1:0] sz);
        case ($urandom_range(5))
            0: return CW'($urandom);
            1: return CW'(-$signed({1'b0, $urandom_range(int'(sz) + 16)}));
            2: return CW'(int'(sz) + $urandom_range(int'(sz) + 16));
            default: return CW'($urandom_range(int'(sz)));
        endcase
    endfunction

    // Check each result transaction against the oldest expectation
    always @(posedge i_clk) begin
        clip_out_t w;
        if (i_rst_n && o_valid && !i_stall) begin
            n_res++;
            if (clipped_q.size() == 0) report_mismatch("unexpected result", 1, 0);
            else begin
                w = clipped_q.pop_front();
                if (o_out_x !== w.x) report_mismatch("out_x", o_out_x, w.x);
                if (o_out_y !== w.y) report_mismatch("out_y", o_out_y, w.y);
                if (o_out_valid !== w.vld) report_mismatch("out_valid", o_out_valid, w.vld);
                if (o_out_last !== w.last) report_mismatch("out_last", o_out_last, w.last);
            end
        end
    end

    // Drive receiver stall at random unless held off or freed
    always @(negedge i_clk)
        i_stall <= rx_block || (!rx_free && $urandom_range(99) < 16);

    task automatic test_directed();
        // square fully inside, then edges crossing the x >= 0 and y >= 0 sides
        send_vertex(16, 16, 0); send_vertex(200, 16, 0); send_vertex(200, 200, 0);
        send_vertex(16, 200, 1);
        send_vertex(-256, 128, 0); send_vertex(512, 128, 0); send_vertex(128, 512, 0);
        send_vertex(128, -256, 1);
        // all outside, then a single vertex inside and outside
        send_vertex(-5, -5, 0); send_vertex(-100, -7, 0); send_vertex(-3, -90, 1);
        send_vertex(100, 100, 1);
        send_vertex(CMAX, CMIN, 1);
        // field extremes and corner points
        send_vertex(CMIN, CMIN, 0); send_vertex(CMAX, CMIN, 0); send_vertex(CMAX, CMAX, 0);
        send_vertex(CMIN, CMAX, 1);
        send_vertex(0, 0, 0); send_vertex(65536, 0, 0); send_vertex(65536, 65536, 1);
        // vertical edge lying outside x >= 0, then edges crossing x = 0
        send_vertex(-1, -1, 0); send_vertex(-1, 5, 0); send_vertex(3, 5, 1);
    endtask

    task automatic test_sizes();
        write_size('0);
        send_vertex(0, 0, 0); send_vertex(4, -4, 0); send_vertex(-4, 4, 1);
        write_size(SMAX);
        send_vertex(CMIN, 7, 0); send_vertex(CMAX, -9, 0); send_vertex(33, CMAX, 1);
        write_size(SW'(1000));
    endtask

    task automatic test_random(int nvtx, bit gaps = 1'b1);
        int len;
        logic [SW-1:0] sz;
        sz = pr_size;
        while (nvtx > 0) begin
            len = $urandom_range(8, 1);
            for (int k = 0; k < len; k++) begin
                send_vertex(rand_coord(sz), rand_coord(sz), k == len - 1, gaps);
                nvtx--;
            end
        end
    endtask

    task automatic test_backpressure();
        wait_drained();
        rx_block = 1'b1;
        fork
            repeat (400) @(negedge i_clk);
            for (int k = 0; k < 12; k++)
                send_vertex(rand_coord(pr_size), rand_coord(pr_size), k == 11, 1'b0);
        join_any
        rx_block = 1'b0;
        wait fork;
        wait_drained();
    endtask

    initial begin
        pr_size = clp_pkg::CLIP_SIZE_RESET;
        pr_hold = 1'b0; pr_hx = '0; pr_hy = '0;
        for (int c = 0; c < NCELL; c++) begin
            pr_fx[c] = '0; pr_fy[c] = '0; pr_px[c] = '0; pr_py[c] = '0;
            pr_started[c] = 1'b0;
        end
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        test_sizes();
        test_random(80);
        test_backpressure();
        write_size(SW'(65536));
        rx_free = 1'b1;
        test_random(80, 1'b0);
        rx_free = 1'b0;
        write_size(SW'($urandom_range(300000)));
        test_random(70);
        wait_drained();
        $display("Covered %0d vertices in %0d rings, %0d results, %0d empty rings.",
                 n_vtx, n_rings, n_res, n_empty);
        if (n_err == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial begin
        #4000000;
        $display("tb: failure");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/clp_pkg.sv
rtl/core/clp_div.sv
rtl/core/clp_cell.sv
rtl/core/clp_sink.sv
rtl/core/polygon_clip_to_square.sv
tb/tb_polygon_clip_to_square_core.sv
